// ----- rtl/meter_response_decoder_top_assert.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef METER_RESPONSE_DECODER_TOP_ASSERT_SVH
`define METER_RESPONSE_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MRD_ASSERT_ALWAYS(lbl, c, r, cond, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (cond)) else $error(msg);
`define MRD_ASSERT_SAME(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) else $error(msg);
`define MRD_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) else $error(msg);
`else
`define MRD_ASSERT_ALWAYS(lbl, c, r, cond, msg)
`define MRD_ASSERT_SAME(lbl, c, r, ante, cons, msg)
`define MRD_ASSERT_NEXT(lbl, c, r, ante, cons, msg)
`endif
`endif

// ----- rtl/mrd_pkg.sv -----
package mrd_pkg;

  localparam int MAX_FRAME_DEFAULT   = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int MIN_FRAME   = 13;
  localparam int MIN_SUMMARY = 15;

  localparam logic [7:0] CRC_POLY   = 8'hB5;
  localparam logic [7:0] ESC_BYTE   = 8'hDB;
  localparam logic [7:0] ESC_END    = 8'hDC;
  localparam logic [7:0] ESC_ESC    = 8'hDD;
  localparam logic [7:0] END_BYTE   = 8'hC0;
  localparam logic [7:0] HDR_START  = 8'h48;
  localparam logic [7:0] CMD_GROUP  = 8'h01;
  localparam logic [7:0] CMD_POWER  = 8'h32;
  localparam logic [7:0] CMD_SUMARY = 8'h31;
  localparam int         POWER_SCALE = 10;

  // positions of unstuffed bytes in the frame
  localparam int POS_HDR    = 1;
  localparam int POS_ZERO_A = 2;
  localparam int POS_ZERO_B = 3;
  localparam int POS_ADDR_L = 4;
  localparam int POS_ADDR_H = 5;
  localparam int POS_CMD_A  = 7;
  localparam int POS_CMD_B  = 8;
  localparam int POS_VAL_0  = 9;
  localparam int POS_VAL_1  = 10;
  localparam int POS_VAL_2  = 11;
  localparam int POS_VAL_3  = 12;
  localparam int CRC_START  = 3;

  typedef enum logic [0:0] {
    REG_ADDR_LOW  = 1'b0,
    REG_ADDR_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_FORMAT  = 3'd0,
    KIND_CRC     = 3'd1,
    KIND_HEADER  = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_POWER   = 3'd4,
    KIND_SUMMARY = 3'd5
  } result_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  value;
  } verdict_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrd_front.sv -----
`include "meter_response_decoder_top_assert.svh"

module mrd_front #(
  parameter int MAX_FRAME = mrd_pkg::MAX_FRAME_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              frame_end,
  output logic              q_push,
  output mrd_pkg::verdict_t q_data
);

  localparam int POS_W = $clog2(MAX_FRAME + 2);

  logic [7:0]       addr_low;
  logic [7:0]       addr_high;
  logic [POS_W-1:0] pos, pos_next;
  logic             esc, esc_next;
  logic             fmt_bad, fmt_bad_next;
  logic             hdr_good, hdr_good_next;
  logic [7:0]       crc, crc_next;
  logic [7:0]       lag0, lag0_next;
  logic [7:0]       lag1, lag1_next;
  logic [1:0][7:0]  cmd, cmd_next;
  logic [3:0][7:0]  val, val_next;
  logic             take;
  logic [7:0]       tb;

  always_comb begin
    pos_next      = pos;
    esc_next      = esc;
    fmt_bad_next  = fmt_bad;
    hdr_good_next = hdr_good;
    crc_next      = crc;
    lag0_next     = lag0;
    lag1_next     = lag1;
    cmd_next      = cmd;
    val_next      = val;
    take          = 1'b0;
    tb            = rx_byte;

    if (esc) begin
      esc_next = 1'b0;
      if (rx_byte == mrd_pkg::ESC_END) begin
        take = 1'b1;
        tb   = mrd_pkg::END_BYTE;
      end else if (rx_byte == mrd_pkg::ESC_ESC) begin
        take = 1'b1;
        tb   = mrd_pkg::ESC_BYTE;
      end else begin
        fmt_bad_next = 1'b1;
      end
    end else if (rx_byte == mrd_pkg::ESC_BYTE) begin
      esc_next = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (pos >= POS_W'(mrd_pkg::CRC_START)) begin
        crc_next = mrd_pkg::crc_fold(crc, lag1);
      end
      lag1_next = lag0;
      lag0_next = tb;
      unique case (pos)
        POS_W'(mrd_pkg::POS_HDR): begin
          if (tb != mrd_pkg::HDR_START) hdr_good_next = 1'b0;
        end
        POS_W'(mrd_pkg::POS_ZERO_A), POS_W'(mrd_pkg::POS_ZERO_B): begin
          if (tb != 8'h00) hdr_good_next = 1'b0;
        end
        POS_W'(mrd_pkg::POS_ADDR_L): begin
          if (tb != addr_low) hdr_good_next = 1'b0;
        end
        POS_W'(mrd_pkg::POS_ADDR_H): begin
          if (tb != addr_high) hdr_good_next = 1'b0;
        end
        POS_W'(mrd_pkg::POS_CMD_A): cmd_next[0] = tb;
        POS_W'(mrd_pkg::POS_CMD_B): cmd_next[1] = tb;
        POS_W'(mrd_pkg::POS_VAL_0): val_next[0] = tb;
        POS_W'(mrd_pkg::POS_VAL_1): val_next[1] = tb;
        POS_W'(mrd_pkg::POS_VAL_2): val_next[2] = tb;
        POS_W'(mrd_pkg::POS_VAL_3): val_next[3] = tb;
        default: ;
      endcase
      if (pos <= POS_W'(MAX_FRAME)) begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  // classification on the frame's last byte
  always_comb begin
    q_data.value = val_next;
    priority if (fmt_bad_next || esc_next || pos_next < POS_W'(mrd_pkg::MIN_FRAME) ||
                 pos_next > POS_W'(MAX_FRAME)) begin
      q_data.kind = mrd_pkg::KIND_FORMAT;
    end else if (lag1_next != crc_next) begin
      q_data.kind = mrd_pkg::KIND_CRC;
    end else if (!hdr_good_next) begin
      q_data.kind = mrd_pkg::KIND_HEADER;
    end else if (cmd_next[0] == mrd_pkg::CMD_GROUP && cmd_next[1] == mrd_pkg::CMD_POWER) begin
      q_data.kind = mrd_pkg::KIND_POWER;
    end else if (cmd_next[0] == mrd_pkg::CMD_GROUP && cmd_next[1] == mrd_pkg::CMD_SUMARY) begin
      q_data.kind = (pos_next < POS_W'(mrd_pkg::MIN_SUMMARY)) ? mrd_pkg::KIND_FORMAT
                                                              : mrd_pkg::KIND_SUMMARY;
    end else begin
      q_data.kind = mrd_pkg::KIND_UNKNOWN;
    end
  end

  assign q_push = accept && frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_low  <= 8'h00;
      addr_high <= 8'h00;
      pos       <= '0;
      esc       <= 1'b0;
      fmt_bad   <= 1'b0;
      hdr_good  <= 1'b1;
      crc       <= 8'h00;
      lag0      <= 8'h00;
      lag1      <= 8'h00;
      cmd       <= '0;
      val       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (mrd_pkg::cfg_reg_t'(cfg_index))
          mrd_pkg::REG_ADDR_LOW:  addr_low  <= cfg_data;
          mrd_pkg::REG_ADDR_HIGH: addr_high <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (frame_end) begin
          pos      <= '0;
          esc      <= 1'b0;
          fmt_bad  <= 1'b0;
          hdr_good <= 1'b1;
          crc      <= 8'h00;
          lag0     <= 8'h00;
          lag1     <= 8'h00;
          cmd      <= '0;
          val      <= '0;
        end else begin
          pos      <= pos_next;
          esc      <= esc_next;
          fmt_bad  <= fmt_bad_next;
          hdr_good <= hdr_good_next;
          crc      <= crc_next;
          lag0     <= lag0_next;
          lag1     <= lag1_next;
          cmd      <= cmd_next;
          val      <= val_next;
        end
      end
    end
  end

  `MRD_ASSERT_ALWAYS(a_pos_sat, clk, rst, pos <= POS_W'(MAX_FRAME + 1), "byte count past saturation")
  `MRD_ASSERT_NEXT(a_frame_clear, clk, rst, accept && frame_end, pos == '0 && !esc && hdr_good, "frame state not cleared")

endmodule

// ----- rtl/mrd_queue.sv -----
`include "meter_response_decoder_top_assert.svh"

module mrd_queue #(
  parameter int DEPTH = mrd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mrd_pkg::verdict_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output mrd_pkg::verdict_t rd_data,
  output logic              empty
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrd_pkg::verdict_t mem [DEPTH];
  logic [IDX_W-1:0]  wr_ptr;
  logic [IDX_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `MRD_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count over depth")
  `MRD_ASSERT_NEXT(a_count_up, clk, rst, do_wr && !do_rd, count == $past(count) + CNT_W'(1), "queue count did not grow")

endmodule

// ----- rtl/mrd_back.sv -----
`include "meter_response_decoder_top_assert.svh"

module mrd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  mrd_pkg::verdict_t     q_data,
  output logic                  q_pop,
  output mrd_pkg::result_kind_t kind,
  output logic [31:0]           reading,
  output logic                  empty,
  input  logic                  pop
);

  logic        out_valid;
  logic        load;
  logic [31:0] reading_next;

  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load;
  assign empty = !out_valid;

  always_comb begin
    unique case (q_data.kind)
      mrd_pkg::KIND_POWER:
        reading_next = 32'(q_data.value[15:0]) * 32'(mrd_pkg::POWER_SCALE);
      mrd_pkg::KIND_SUMMARY:
        reading_next = q_data.value;
      default:
        reading_next = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      kind      <= mrd_pkg::KIND_FORMAT;
      reading   <= 32'h0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        kind      <= q_data.kind;
        reading   <= reading_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MRD_ASSERT_SAME(a_zero_reading, clk, rst, out_valid && kind != mrd_pkg::KIND_POWER && kind != mrd_pkg::KIND_SUMMARY, reading == 32'h0, "nonzero reading on error result")

endmodule

// ----- rtl/meter_response_decoder_top.sv -----
// Meter reply decoder. Raw bytes of a SLIP-style stuffed reply frame are pushed one per cycle
// while full is low, with frame_end on the last raw byte. Each frame gives exactly one result
// (result_kind and reading): its verdict is queued on the final byte and moves to the output
// register once it is free. Finished verdicts wait in a QUEUE_DEPTH-entry queue ahead of the
// output register; full rises only when the queue holds that many verdicts with one more
// unread in the output register, and it then holds off all bytes. Meter address bytes are
// written via cfg_wr_en/cfg_index/cfg_data; the user must do so between frames, unenforced.
module meter_response_decoder_top #(
  parameter int MAX_FRAME   = mrd_pkg::MAX_FRAME_DEFAULT,
  parameter int QUEUE_DEPTH = mrd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  result_kind,
  output logic [31:0] reading
);

  logic                  accept;
  logic                  q_push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  mrd_pkg::verdict_t     q_wr_data;
  mrd_pkg::verdict_t     q_rd_data;
  mrd_pkg::result_kind_t kind;

  assign full        = q_full;
  assign accept      = push && !q_full;
  assign result_kind = kind;

  mrd_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .frame_end (frame_end),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  mrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  mrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .kind    (kind),
    .reading (reading),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
